/* sv/erxf_pkg.sv */
// Shared types and constants for the Ethernet IPv4/ARP receive filter.
`default_nettype none

package erxf_pkg;

    localparam int unsigned STORE_WORDS = 21;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned CSUM_W      = 20;

    localparam logic [14:0] CSUM_FIRST_WORD = 15'd7;
    localparam logic [14:0] CSUM_LAST_WORD  = 15'd16;

    localparam logic [15:0] ETHTYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETHTYPE_ADDR_RES = 16'h0806;
    localparam logic [7:0]  IPV4_VHL       = 8'h45;
    localparam logic [15:0] FRAG_DF_ONLY   = 16'h4000;
    localparam logic [15:0] ONES_MASK      = 16'hffff;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] ARP_HLEN_PLEN  = 16'h0604;
    localparam logic [15:0] IPV4_HDR_BYTES = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

    localparam logic [15:0] ETH_MIN_BYTES  = 16'd14;
    localparam logic [15:0] IPV4_MIN_BYTES = 16'd34;
    localparam logic [15:0] L4_MIN_BYTES   = 16'd42;

    localparam logic [31:0] LOCAL_IP_RESET = 32'h0A00020F;

    typedef enum logic [3:0] {
        VERDICT_UDP       = 4'd0,
        VERDICT_ICMP      = 4'd1,
        VERDICT_ARP       = 4'd2,
        VERDICT_OTHER     = 4'd3,
        VERDICT_SHORT     = 4'd4,
        VERDICT_VERSION   = 4'd5,
        VERDICT_CHECKSUM  = 4'd6,
        VERDICT_FRAGMENT  = 4'd7,
        VERDICT_NOT_OURS  = 4'd8,
        VERDICT_PROTOCOL  = 4'd9,
        VERDICT_UDP_LEN   = 4'd10,
        VERDICT_ARP_HDR   = 4'd11
    } verdict_t;

    typedef logic [STORE_WORDS-1:0][15:0] hdr_store_t;

    typedef struct packed {
        logic [COUNT_W-1:0] total;
        logic [CSUM_W-1:0]  csum;
    } pend_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] icmp_ident;
        logic [15:0] body_len;
        logic [15:0] arp_opcode;
        logic [31:0] arp_target_ip;
        logic [47:0] arp_sender_mac;
    } result_t;

endpackage

`default_nettype wire

/* sv/erxf_frame_capture.sv */
// Per-beat frame capture: byte count, header word store, checksum sum, end-of-frame hold.
`default_nettype none

module erxf_frame_capture
    import erxf_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        beat_accept,
    input  wire logic [15:0] data_word,
    input  wire logic        last,
    input  wire logic        single_byte,
    input  wire logic        pend_take,
    output logic             pend_valid,
    output pend_t            pend,
    output hdr_store_t       store
);

    localparam logic [COUNT_W:0] MAX_BYTES = (COUNT_W + 1)'(MAX_FRAME_BYTES);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [CSUM_W-1:0]  csum_reg, csum_next;
    logic               pend_valid_reg, pend_valid_next;
    pend_t              pend_reg, pend_next;
    hdr_store_t         store_reg;

    logic               half;
    logic [15:0]        word;
    logic [14:0]        idx;
    logic               in_store;
    logic               in_csum;
    logic [CSUM_W-1:0]  csum_upd;
    logic [COUNT_W:0]   count_inc;
    logic [COUNT_W-1:0] count_sat;

    always_comb begin
        half      = last && single_byte;
        word      = half ? {data_word[15:8], 8'h00} : data_word;
        idx       = count_reg[COUNT_W-1:1];
        in_store  = idx < 15'(STORE_WORDS);
        in_csum   = (idx >= CSUM_FIRST_WORD) && (idx <= CSUM_LAST_WORD);
        csum_upd  = in_csum ? csum_reg + CSUM_W'(word) : csum_reg;
        count_inc = {1'b0, count_reg} + (half ? (COUNT_W + 1)'(1) : (COUNT_W + 1)'(2));
        count_sat = (count_inc > MAX_BYTES) ? MAX_BYTES[COUNT_W-1:0]
                                            : count_inc[COUNT_W-1:0];

        count_next      = count_reg;
        csum_next       = csum_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg && !pend_take;
        if (beat_accept) begin
            if (last) begin
                count_next      = '0;
                csum_next       = '0;
                pend_next.total = count_sat;
                pend_next.csum  = csum_upd;
                pend_valid_next = 1'b1;
            end else begin
                count_next = count_sat;
                csum_next  = csum_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            csum_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            csum_reg       <= csum_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        if (beat_accept && in_store) begin
            store_reg[idx[4:0]] <= word;
        end
    end

    assign pend_valid = pend_valid_reg;
    assign pend       = pend_reg;
    assign store      = store_reg;

endmodule

`default_nettype wire

/* sv/erxf_judge.sv */
// Verdict logic: header checks and field extraction for one finished frame.
`default_nettype none

module erxf_judge
    import erxf_pkg::*;
(
    input  wire hdr_store_t  store,
    input  wire pend_t       pend,
    input  wire logic [31:0] local_ip_addr,
    output result_t          result
);

    logic [16:0] fold1;
    logic [16:0] fold2;
    logic        csum_ok;
    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic [15:0] rest;
    logic [7:0]  proto;
    logic [15:0] total;

    always_comb begin
        total   = pend.total;
        fold1   = {1'b0, pend.csum[15:0]} + 17'(pend.csum[CSUM_W-1:16]);
        fold2   = {1'b0, fold1[15:0]} + 17'(fold1[16]);
        csum_ok = fold2[15:0] == ONES_MASK;
        ip_len  = store[8] - IPV4_HDR_BYTES;
        udp_len = ip_len - UDP_HDR_BYTES;
        rest    = total - L4_MIN_BYTES;
        proto   = store[11][7:0];

        result = '0;
        priority if (total < ETH_MIN_BYTES) begin
            result.verdict = VERDICT_SHORT;
        end else if (store[6] == ETHTYPE_ADDR_RES) begin
            if (total < L4_MIN_BYTES) begin
                result.verdict = VERDICT_SHORT;
            end else if (store[7] != ARP_HTYPE_ETH || store[8] != ETHTYPE_IPV4
                         || store[9] != ARP_HLEN_PLEN) begin
                result.verdict = VERDICT_ARP_HDR;
            end else begin
                result.verdict        = VERDICT_ARP;
                result.source_ip      = {store[14], store[15]};
                result.arp_opcode     = store[10];
                result.arp_target_ip  = {store[19], store[20]};
                result.arp_sender_mac = {store[11], store[12], store[13]};
            end
        end else if (store[6] != ETHTYPE_IPV4) begin
            result.verdict = VERDICT_OTHER;
        end else if (total < IPV4_MIN_BYTES) begin
            result.verdict = VERDICT_SHORT;
        end else if (store[7][15:8] != IPV4_VHL) begin
            result.verdict = VERDICT_VERSION;
        end else if (!csum_ok) begin
            result.verdict = VERDICT_CHECKSUM;
        end else if (store[10] != '0 && store[10] != FRAG_DF_ONLY) begin
            result.verdict = VERDICT_FRAGMENT;
        end else if ({store[15], store[16]} != local_ip_addr) begin
            result.verdict = VERDICT_NOT_OURS;
        end else if (proto == PROTO_UDP) begin
            if (total < L4_MIN_BYTES) begin
                result.verdict = VERDICT_SHORT;
            end else if (store[19] != ip_len || udp_len > rest) begin
                result.verdict = VERDICT_UDP_LEN;
            end else begin
                result.verdict     = VERDICT_UDP;
                result.source_ip   = {store[13], store[14]};
                result.source_port = store[17];
                result.dest_port   = store[18];
                result.body_len    = udp_len;
            end
        end else if (proto == PROTO_ICMP) begin
            if (total < L4_MIN_BYTES) begin
                result.verdict = VERDICT_SHORT;
            end else begin
                result.verdict     = VERDICT_ICMP;
                result.source_ip   = {store[13], store[14]};
                result.icmp_ident  = store[19];
                result.body_len    = (ip_len < rest) ? ip_len : rest;
            end
        end else begin
            result.verdict = VERDICT_PROTOCOL;
        end
    end

endmodule

`default_nettype wire

/* sv/ethernet_ipv4_receive_filter.sv */
// Top level of the Ethernet IPv4/ARP receive filter.
// A frame's end is held as a pending verdict, then moved to the result register.
// Throughput: one word per cycle; s_ready drops only while a finished frame waits
// for a stalled result register.
// Reset: synchronous active-low aresetn clears the count, sum and valids, and loads
// local_ip_addr with 10.0.2.15.
`default_nettype none

module ethernet_ipv4_receive_filter
    import erxf_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_data_word,
    input  wire logic        s_last,
    input  wire logic        s_single_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_verdict,
    output logic [31:0]      m_source_ip,
    output logic [15:0]      m_source_port,
    output logic [15:0]      m_dest_port,
    output logic [15:0]      m_icmp_ident,
    output logic [15:0]      m_body_len,
    output logic [15:0]      m_arp_opcode,
    output logic [31:0]      m_arp_target_ip,
    output logic [47:0]      m_arp_sender_mac
);

    logic [31:0] local_ip_reg, local_ip_next;
    logic        m_valid_reg, m_valid_next;
    result_t     result_reg, result_next;

    logic        beat_accept;
    logic        out_free;
    logic        pend_take;
    logic        pend_valid;
    pend_t       pend;
    hdr_store_t  store;
    result_t     judged;

    assign cfg_ready   = 1'b1;
    assign out_free    = !m_valid_reg || m_ready;
    assign pend_take   = pend_valid && out_free;
    // a held frame end blocks new beats, since they would overwrite its header words
    assign s_ready     = !pend_valid || out_free;
    assign beat_accept = s_valid && s_ready;

    erxf_frame_capture #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_accept (beat_accept),
        .data_word   (s_data_word),
        .last        (s_last),
        .single_byte (s_single_byte),
        .pend_take   (pend_take),
        .pend_valid  (pend_valid),
        .pend        (pend),
        .store       (store)
    );

    erxf_judge u_judge (
        .store         (store),
        .pend          (pend),
        .local_ip_addr (local_ip_reg),
        .result        (judged)
    );

    always_comb begin
        local_ip_next = (cfg_valid && cfg_ready) ? cfg_data : local_ip_reg;
        result_next   = pend_take ? judged : result_reg;
        if (pend_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_ip_reg <= LOCAL_IP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            local_ip_reg <= local_ip_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_verdict        = result_reg.verdict;
    assign m_source_ip      = result_reg.source_ip;
    assign m_source_port    = result_reg.source_port;
    assign m_dest_port      = result_reg.dest_port;
    assign m_icmp_ident     = result_reg.icmp_ident;
    assign m_body_len       = result_reg.body_len;
    assign m_arp_opcode     = result_reg.arp_opcode;
    assign m_arp_target_ip  = result_reg.arp_target_ip;
    assign m_arp_sender_mac = result_reg.arp_sender_mac;

    a_stall_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (pend_valid && m_valid && !m_ready))
        else $error("input stalled without a blocked frame end");

    a_last_makes_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> pend_valid)
        else $error("last beat did not produce a pending verdict");

    a_pend_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid && out_free) |=> m_valid)
        else $error("pending verdict not moved to result register");

    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_verdict <= VERDICT_ARP_HDR))
        else $error("verdict code out of range");

endmodule

`default_nettype wire

/* tb/erxf_verdict_checker.sv */
`timescale 1ns / 1ps
// Checker for the receive filter: tracks frame beats, predicts each verdict and compares it.
module erxf_verdict_checker
    import erxf_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [31:0] cfg_data,

    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [15:0] s_data_word,
    input  wire logic        s_last,
    input  wire logic        s_single_byte,

    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [3:0]  m_verdict,
    input  wire logic [31:0] m_source_ip,
    input  wire logic [15:0] m_source_port,
    input  wire logic [15:0] m_dest_port,
    input  wire logic [15:0] m_icmp_ident,
    input  wire logic [15:0] m_body_len,
    input  wire logic [15:0] m_arp_opcode,
    input  wire logic [31:0] m_arp_target_ip,
    input  wire logic [47:0] m_arp_sender_mac,

    output int               fail_count,
    output int               pending
);

    int unsigned frame_bytes = 0;
    logic [15:0] hdr_words[STORE_WORDS];
    logic [19:0] hdr_sum = '0;
    logic [31:0] station_ip = LOCAL_IP_RESET;
    result_t     awaited_verdicts[$];
    int          errs = 0;

    function automatic logic [31:0] word_pair(input int i);
        return {hdr_words[i], hdr_words[i + 1]};
    endfunction

    function automatic result_t grade_frame(input int unsigned total);
        result_t     r;
        logic [15:0] ip_pay;
        logic [15:0] udp_pay;
        int unsigned folded;
        int unsigned rest;
        r = '0;
        r.verdict = VERDICT_SHORT;
        if (total < ETH_MIN_BYTES) return r;
        if (hdr_words[6] == ETHTYPE_ADDR_RES) begin
            if (total < L4_MIN_BYTES) return r;
            if (hdr_words[7] != ARP_HTYPE_ETH || hdr_words[8] != ETHTYPE_IPV4
                    || hdr_words[9] != ARP_HLEN_PLEN) begin
                r.verdict = VERDICT_ARP_HDR;
                return r;
            end
            r.verdict        = VERDICT_ARP;
            r.source_ip      = word_pair(14);
            r.arp_opcode     = hdr_words[10];
            r.arp_target_ip  = word_pair(19);
            r.arp_sender_mac = {hdr_words[11], hdr_words[12], hdr_words[13]};
            return r;
        end
        if (hdr_words[6] != ETHTYPE_IPV4) begin
            r.verdict = VERDICT_OTHER;
            return r;
        end
        if (total < IPV4_MIN_BYTES) return r;
        r.verdict = VERDICT_VERSION;
        if (hdr_words[7][15:8] != IPV4_VHL) return r;
        // one's-complement fold of the 20-bit header sum
        folded = (hdr_sum & 20'hffff) + (hdr_sum >> 16);
        folded = folded + (folded >> 16);
        r.verdict = VERDICT_CHECKSUM;
        if ((folded & 32'hffff) != ONES_MASK) return r;
        r.verdict = VERDICT_FRAGMENT;
        if (hdr_words[10] != 16'h0 && hdr_words[10] != FRAG_DF_ONLY) return r;
        r.verdict = VERDICT_NOT_OURS;
        if (word_pair(15) != station_ip) return r;
        ip_pay = hdr_words[8] - IPV4_HDR_BYTES;
        if (hdr_words[11][7:0] == PROTO_UDP) begin
            r.verdict = VERDICT_SHORT;
            if (total < L4_MIN_BYTES) return r;
            r.verdict = VERDICT_UDP_LEN;
            if (hdr_words[19] != ip_pay) return r;
            udp_pay = ip_pay - UDP_HDR_BYTES;
            if (udp_pay > total - L4_MIN_BYTES) return r;
            r.verdict     = VERDICT_UDP;
            r.source_ip   = word_pair(13);
            r.source_port = hdr_words[17];
            r.dest_port   = hdr_words[18];
            r.body_len    = udp_pay;
        end else if (hdr_words[11][7:0] == PROTO_ICMP) begin
            r.verdict = VERDICT_SHORT;
            if (total < L4_MIN_BYTES) return r;
            rest          = total - L4_MIN_BYTES;
            r.verdict     = VERDICT_ICMP;
            r.source_ip   = word_pair(13);
            r.icmp_ident  = hdr_words[19];
            r.body_len    = (ip_pay < rest) ? ip_pay : 16'(rest);
        end else begin
            r.verdict = VERDICT_PROTOCOL;
        end
        return r;
    endfunction

    always @(posedge aclk) begin : track
        result_t     got;
        result_t     exp;
        logic [15:0] w;
        logic        half;
        int unsigned idx;
        if (!aresetn) begin
            frame_bytes = 0;
            hdr_sum     = '0;
            station_ip  = LOCAL_IP_RESET;
            foreach (hdr_words[i]) hdr_words[i] = '0;
            awaited_verdicts.delete();
        end else begin
            // result first: a verdict leaving now belongs to an older frame
            if (m_valid && m_ready) begin
                got = '{verdict_t'(m_verdict), m_source_ip, m_source_port, m_dest_port,
                        m_icmp_ident, m_body_len, m_arp_opcode, m_arp_target_ip,
                        m_arp_sender_mac};
                if (awaited_verdicts.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t unexpected verdict beat: v=%0d sip=%h", $realtime,
                                 m_verdict, m_source_ip);
                end else begin
                    exp = awaited_verdicts.pop_front();
                    if (got !== exp) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("%0t verdict mismatch", $realtime);
                            $display("  exp v=%0d sip=%h sp=%h dp=%h id=%h len=%h",
                                     exp.verdict, exp.source_ip, exp.source_port,
                                     exp.dest_port, exp.icmp_ident, exp.body_len);
                            $display("      op=%h tip=%h mac=%h",
                                     exp.arp_opcode, exp.arp_target_ip, exp.arp_sender_mac);
                            $display("  got v=%0d sip=%h sp=%h dp=%h id=%h len=%h",
                                     m_verdict, m_source_ip, m_source_port, m_dest_port,
                                     m_icmp_ident, m_body_len);
                            $display("      op=%h tip=%h mac=%h",
                                     m_arp_opcode, m_arp_target_ip, m_arp_sender_mac);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) station_ip = cfg_data;
            if (s_valid && s_ready) begin
                w    = s_data_word;
                half = s_last && s_single_byte;
                if (half) w[7:0] = 8'h00;
                idx = frame_bytes >> 1;
                if (idx < STORE_WORDS) hdr_words[idx] = w;
                if (idx >= CSUM_FIRST_WORD && idx <= CSUM_LAST_WORD) hdr_sum = hdr_sum + w;
                frame_bytes = frame_bytes + (half ? 1 : 2);
                if (frame_bytes > MAX_FRAME_BYTES) frame_bytes = MAX_FRAME_BYTES;
                if (s_last) begin
                    awaited_verdicts.push_back(grade_frame(frame_bytes));
                    frame_bytes = 0;
                    hdr_sum     = '0;
                end
            end
        end
        fail_count <= errs;
        pending    <= awaited_verdicts.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench top: feeds Ethernet frames and station address writes to the receive filter.
module tb;
    import erxf_pkg::*;

    localparam int unsigned FRAME_LIMIT = 2048;
    localparam int          STALL_LIMIT = 4000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          BEATS_PER_PHASE = 215;
    localparam logic [15:0] ARP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_REPLY   = 16'd2;

    typedef enum {FK_UDP, FK_ICMP, FK_ARP, FK_OTHER, FK_PROTO, FK_NOISE} frame_kind_t;
    typedef enum {
        FL_NONE, FL_VERSION, FL_CSUM, FL_FRAG, FL_DEST, FL_ULEN,
        FL_FIT, FL_WRAP, FL_IPLEN, FL_ARPHDR, FL_TRUNC
    } flaw_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_data_word = '0;
    logic        s_last = 1'b0;
    logic        s_single_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_verdict;
    logic [31:0] m_source_ip;
    logic [15:0] m_source_port;
    logic [15:0] m_dest_port;
    logic [15:0] m_icmp_ident;
    logic [15:0] m_body_len;
    logic [15:0] m_arp_opcode;
    logic [31:0] m_arp_target_ip;
    logic [47:0] m_arp_sender_mac;

    int          fail_count;
    int          pending;
    logic [7:0]  fb[$];
    logic [31:0] station_ip = LOCAL_IP_RESET;
    logic        quiet = 1'b0;
    int          beats_sent = 0;
    int          stall_cycles = 0;

    ethernet_ipv4_receive_filter #(.MAX_FRAME_BYTES(FRAME_LIMIT)) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_last           (s_last),
        .s_single_byte    (s_single_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict        (m_verdict),
        .m_source_ip      (m_source_ip),
        .m_source_port    (m_source_port),
        .m_dest_port      (m_dest_port),
        .m_icmp_ident     (m_icmp_ident),
        .m_body_len       (m_body_len),
        .m_arp_opcode     (m_arp_opcode),
        .m_arp_target_ip  (m_arp_target_ip),
        .m_arp_sender_mac (m_arp_sender_mac)
    );

    erxf_verdict_checker #(.MAX_FRAME_BYTES(FRAME_LIMIT)) verdict_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_last           (s_last),
        .s_single_byte    (s_single_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict        (m_verdict),
        .m_source_ip      (m_source_ip),
        .m_source_port    (m_source_port),
        .m_dest_port      (m_dest_port),
        .m_icmp_ident     (m_icmp_ident),
        .m_body_len       (m_body_len),
        .m_arp_opcode     (m_arp_opcode),
        .m_arp_target_ip  (m_arp_target_ip),
        .m_arp_sender_mac (m_arp_sender_mac),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void put_random(input int n);
        repeat (n) fb.push_back(8'($urandom));
    endfunction

    function automatic void put16(input logic [15:0] v);
        fb.push_back(v[15:8]);
        fb.push_back(v[7:0]);
    endfunction

    // Builds one frame of the given kind, optionally broken, then streams it out.
    task automatic send_frame(input frame_kind_t kind, input flaw_t flaw, input int pay,
                              input int pad, input int keep);
        logic [15:0] ip_hdr[10];
        logic [15:0] etype;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [15:0] hw;
        logic [15:0] pt;
        logic [15:0] hp;
        logic [7:0]  proto;
        logic [7:0]  vhl;
        logic [31:0] dst_ip;
        int unsigned acc;
        int          n;
        int          gap;
        logic [15:0] w;
        logic        lst;
        logic        sb;
        fb.delete();
        if (kind == FK_NOISE) begin
            put_random(pay);
        end else begin
            put_random(12);
            case (kind)
                FK_ARP:   etype = ETHTYPE_ADDR_RES;
                FK_OTHER: do etype = 16'($urandom);
                          while (etype == ETHTYPE_IPV4 || etype == ETHTYPE_ADDR_RES);
                default:  etype = ETHTYPE_IPV4;
            endcase
            put16(etype);
            if (kind == FK_ARP) begin
                hw = ARP_HTYPE_ETH;
                pt = ETHTYPE_IPV4;
                hp = ARP_HLEN_PLEN;
                if (flaw == FL_ARPHDR) begin
                    case ($urandom_range(0, 2))
                        0:       hw ^= 16'($urandom_range(1, 65535));
                        1:       pt ^= 16'($urandom_range(1, 65535));
                        default: hp ^= 16'($urandom_range(1, 65535));
                    endcase
                end
                put16(hw);
                put16(pt);
                put16(hp);
                case ($urandom_range(0, 3))
                    0:       put16(ARP_REQUEST);
                    1:       put16(ARP_REPLY);
                    default: put16(16'($urandom));
                endcase
                put_random(20);    // sender MAC/IP, target MAC/IP
                put_random(pay);
            end else if (kind == FK_OTHER) begin
                put_random(pay);
            end else begin
                if (kind == FK_UDP) begin
                    proto = PROTO_UDP;
                end else if (kind == FK_ICMP) begin
                    proto = PROTO_ICMP;
                end else begin
                    do proto = 8'($urandom); while (proto == PROTO_UDP || proto == PROTO_ICMP);
                end
                udp_len = UDP_HDR_BYTES + 16'(pay);
                ip_len  = IPV4_HDR_BYTES + udp_len;
                case (flaw)
                    FL_ULEN: udp_len ^= 16'($urandom_range(1, 65535));
                    FL_FIT: begin
                        udp_len += 16'($urandom_range(1, 16));
                        ip_len = IPV4_HDR_BYTES + udp_len;
                    end
                    FL_WRAP: begin
                        // IP length under the header size wraps the UDP length
                        ip_len  = 16'($urandom_range(0, 19));
                        udp_len = ip_len - IPV4_HDR_BYTES;
                    end
                    FL_IPLEN: begin
                        case ($urandom_range(0, 3))
                            0:       ip_len = 16'hffff;
                            1:       ip_len = 16'h0000;
                            2:       ip_len = 16'($urandom);
                            default: ip_len = IPV4_HDR_BYTES + 16'($urandom_range(0, pay + 8));
                        endcase
                    end
                    default: ;
                endcase
                vhl = IPV4_VHL;
                if (flaw == FL_VERSION) begin
                    do vhl = 8'($urandom); while (vhl == IPV4_VHL);
                end
                dst_ip = station_ip;
                if (flaw == FL_DEST) dst_ip ^= ($urandom | 32'h1);
                ip_hdr[0] = {vhl, 8'($urandom)};
                ip_hdr[1] = ip_len;
                ip_hdr[2] = 16'($urandom);
                ip_hdr[3] = $urandom_range(0, 1) ? FRAG_DF_ONLY : 16'h0000;
                if (flaw == FL_FRAG) begin
                    do ip_hdr[3] = 16'($urandom);
                    while (ip_hdr[3] == 16'h0000 || ip_hdr[3] == FRAG_DF_ONLY);
                end
                ip_hdr[4] = {8'($urandom), proto};
                ip_hdr[5] = 16'h0000;
                {ip_hdr[6], ip_hdr[7]} = $urandom;
                {ip_hdr[8], ip_hdr[9]} = dst_ip;
                acc = 0;
                foreach (ip_hdr[i]) acc += ip_hdr[i];
                acc = (acc & 32'hffff) + (acc >> 16);
                acc = (acc & 32'hffff) + (acc >> 16);
                ip_hdr[5] = ~16'(acc);
                if (flaw == FL_CSUM) ip_hdr[5] ^= 16'($urandom_range(1, 65535));
                foreach (ip_hdr[i]) put16(ip_hdr[i]);
                if (proto == PROTO_UDP) begin
                    put_random(4);
                    put16(udp_len);
                    put_random(2);
                end else begin
                    put_random(8);
                end
                put_random(pay);
            end
            put_random(pad);
        end
        if (flaw == FL_TRUNC && fb.size() > 1) keep = $urandom_range(1, fb.size() - 1);
        if (keep > 0 && keep < fb.size()) fb = fb[0:keep - 1];

        n = fb.size();
        for (int i = 0; i < n; i += 2) begin
            lst = (i + 2 >= n);
            // the low byte of a partial last word is junk on purpose
            w  = {fb[i], (i + 1 < n) ? fb[i + 1] : 8'($urandom)};
            sb = lst ? (i + 1 >= n) : 1'($urandom);
            gap = 0;
            if (!quiet) begin
                while ($urandom_range(0, 99) < 11) gap++;
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid       <= 1'b1;
            s_data_word   <= w;
            s_last        <= lst;
            s_single_byte <= sb;
            do @(posedge aclk); while (!s_ready);
            beats_sent++;
        end
    endtask

    // Drops valid and waits until every verdict in flight has come out.
    task automatic drain_verdicts();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [31:0] ip_val;
        int          phase_end;
        int          r;
        int          pay;
        frame_kind_t kind;
        flaw_t       flaw;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames, station address still at its reset value
        send_frame(FK_UDP,   FL_NONE,    0,  0, 0);
        send_frame(FK_UDP,   FL_NONE,    17, 0, 0);
        send_frame(FK_ICMP,  FL_NONE,    0,  0, 0);
        send_frame(FK_ICMP,  FL_IPLEN,   12, 3, 0);
        send_frame(FK_ICMP,  FL_IPLEN,   30, 0, 0);
        send_frame(FK_ARP,   FL_NONE,    0,  0, 0);
        send_frame(FK_ARP,   FL_ARPHDR,  4,  0, 0);
        send_frame(FK_OTHER, FL_NONE,    10, 0, 0);
        send_frame(FK_NOISE, FL_NONE,    1,  0, 0);
        send_frame(FK_UDP,   FL_NONE,    8,  0, 13);
        send_frame(FK_UDP,   FL_NONE,    8,  0, 33);
        send_frame(FK_UDP,   FL_NONE,    8,  0, 41);
        send_frame(FK_ICMP,  FL_NONE,    0,  0, 40);
        send_frame(FK_ARP,   FL_NONE,    0,  0, 41);
        send_frame(FK_UDP,   FL_VERSION, 4,  0, 0);
        send_frame(FK_UDP,   FL_CSUM,    4,  0, 0);
        send_frame(FK_UDP,   FL_FRAG,    4,  0, 0);
        send_frame(FK_ICMP,  FL_DEST,    4,  0, 0);
        send_frame(FK_PROTO, FL_NONE,    4,  0, 0);
        send_frame(FK_UDP,   FL_ULEN,    6,  0, 0);
        send_frame(FK_UDP,   FL_FIT,     6,  0, 0);
        send_frame(FK_UDP,   FL_WRAP,    6,  0, 0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       ip_val = 32'h0000_0000;
                1:       ip_val = 32'hffff_ffff;
                default: ip_val = $urandom;
            endcase
            drain_verdicts();
            repeat (SETTLE_CYCLES) @(posedge aclk);
            cfg_valid <= 1'b1;
            cfg_data  <= ip_val;
            do @(posedge aclk); while (!cfg_ready);
            cfg_valid  <= 1'b0;
            station_ip = ip_val;
            quiet     <= (phase == 2);

            phase_end = beats_sent + BEATS_PER_PHASE;
            while (beats_sent < phase_end) begin
                if ($urandom_range(0, 99) < 3) drain_verdicts();
                r = $urandom_range(0, 99);
                if (r < 35)      kind = FK_UDP;
                else if (r < 60) kind = FK_ICMP;
                else if (r < 78) kind = FK_ARP;
                else if (r < 85) kind = FK_OTHER;
                else if (r < 92) kind = FK_PROTO;
                else             kind = FK_NOISE;
                flaw = ($urandom_range(0, 99) < 65) ? FL_NONE : flaw_t'($urandom_range(1, 10));
                if (kind == FK_NOISE)              pay = $urandom_range(1, 60);
                else if ($urandom_range(0, 9) == 0) pay = $urandom_range(0, 200);
                else                                pay = $urandom_range(0, 24);
                send_frame(kind, flaw, pay, $urandom_range(0, 1) ? $urandom_range(0, 5) : 0, 0);
            end
        end

        drain_verdicts();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/erxf_pkg.sv
sv/erxf_frame_capture.sv
sv/erxf_judge.sv
sv/ethernet_ipv4_receive_filter.sv
tb/erxf_verdict_checker.sv
tb/tb.sv
